FILE: rtl/core/mqbh_pkg.sv
// Shared types, codes and defaults for the multi-queue binary max-heap.
`default_nettype none

package mqbh_pkg;

    // Default sizes of the heap bank.
    localparam int MQBH_QUEUE_DEPTH = 128;
    localparam int MQBH_NUM_QUEUES  = 16;
    localparam int MQBH_KEY_WIDTH   = 32;

    // Fixed field widths of the transaction payloads.
    localparam int QSEL_W     = 4;
    localparam int KEY_IO_W   = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_IO_W = 8;

    // Operation codes.
    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                       action;
        logic [QSEL_W-1:0]          queue_sel;
        logic signed [KEY_IO_W-1:0] key_in;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_IO_W-1:0] key_out;
        logic [STATUS_W-1:0]        status;
        logic [COUNT_IO_W-1:0]      count_after;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UP_CHK,
        S_UP_CMP,
        S_EX_ROOT,
        S_EX_LAST,
        S_DN_CHK,
        S_DN_RDR,
        S_DN_CMP,
        S_FIN
    } t_state;

    // Which heap slot the memory read port addresses.
    typedef enum logic [2:0] {
        RD_ROOT,
        RD_LAST,
        RD_PARENT,
        RD_LEFT,
        RD_RIGHT
    } t_rd_sel;

    // What the memory write port stores at the current hole.
    typedef enum logic [1:0] {
        WR_KEY,
        WR_RDATA,
        WR_CHILD
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    init;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_root;
        logic    cap_last;
        logic    cap_left;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    step_up;
        logic    step_down;
        logic    finish;
    } t_cmd;

    typedef struct packed {
        logic is_ext;
        logic bad_q;
        logic full;
        logic empty;
        logic pos_zero;
        logic parent_less;
        logic last_zero;
        logic has_left;
        logic down_move;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/core/mqbh_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module mqbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/mqbh_ctrl.sv
// Sequencing state machine for heap insert and extract operations.
`default_nettype none

module mqbh_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire mqbh_pkg::t_sts i_sts,
    output mqbh_pkg::t_cmd     o_cmd
);
    import mqbh_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.rd_sel = RD_ROOT;
        o_cmd.wr_sel = WR_KEY;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.bad_q || (!i_sts.is_ext && i_sts.full) ||
                    (i_sts.is_ext && i_sts.empty)) begin
                    n_state = S_FIN;
                end else if (!i_sts.is_ext) begin
                    o_cmd.init = 1'b1;
                    n_state    = S_UP_CHK;
                end else begin
                    o_cmd.init   = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_ROOT;
                    n_state      = S_EX_ROOT;
                end
            end
            S_UP_CHK: begin
                if (i_sts.pos_zero) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_KEY;
                    n_state      = S_FIN;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PARENT;
                    n_state      = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_sts.parent_less) begin
                    o_cmd.wr_sel  = WR_RDATA;
                    o_cmd.step_up = 1'b1;
                    n_state       = S_UP_CHK;
                end else begin
                    o_cmd.wr_sel = WR_KEY;
                    n_state      = S_FIN;
                end
            end
            S_EX_ROOT: begin
                o_cmd.cap_root = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = RD_LAST;
                n_state        = S_EX_LAST;
            end
            S_EX_LAST: begin
                o_cmd.cap_last = 1'b1;
                n_state        = i_sts.last_zero ? S_FIN : S_DN_CHK;
            end
            S_DN_CHK: begin
                if (i_sts.has_left) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LEFT;
                    n_state      = S_DN_RDR;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_KEY;
                    n_state      = S_FIN;
                end
            end
            S_DN_RDR: begin
                o_cmd.cap_left = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = RD_RIGHT;
                n_state        = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_sts.down_move) begin
                    o_cmd.wr_sel    = WR_CHILD;
                    o_cmd.step_down = 1'b1;
                    n_state         = S_DN_CHK;
                end else begin
                    o_cmd.wr_sel = WR_KEY;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/mqbh_dpath.sv
// Heap datapath: key memory, per-queue counts, sift registers and result register.
`default_nettype none

module mqbh_dpath #(
    parameter int QUEUE_DEPTH = mqbh_pkg::MQBH_QUEUE_DEPTH,
    parameter int NUM_QUEUES  = mqbh_pkg::MQBH_NUM_QUEUES,
    parameter int KEY_WIDTH   = mqbh_pkg::MQBH_KEY_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mqbh_pkg::t_in_item i_in_data,
    input  wire mqbh_pkg::t_cmd     i_cmd,
    output mqbh_pkg::t_sts          o_sts,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output mqbh_pkg::t_out_item     o_out_data
);
    import mqbh_pkg::*;

    // Queue numbers beyond the select field can never be addressed.
    localparam int NQU = (NUM_QUEUES < (2 ** QSEL_W)) ? NUM_QUEUES : (2 ** QSEL_W);
    localparam int QIW = (NQU > 1) ? $clog2(NQU) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int IW  = $clog2(QUEUE_DEPTH);
    localparam int PW  = IW + 2;
    localparam int MEM_DEPTH = NQU * QUEUE_DEPTH;
    localparam int AW  = $clog2(MEM_DEPTH);
    localparam logic [KEY_WIDTH-1:0] KEY_SIGN = {1'b1, {(KEY_WIDTH - 1){1'b0}}};

    // Keys are stored with the sign bit flipped so an unsigned compare orders them.
    logic                 r_action;
    logic [QSEL_W-1:0]    r_q;
    logic [AW-1:0]        r_base;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] r_root;
    logic [KEY_WIDTH-1:0] r_left;
    logic [IW-1:0]        r_pos;
    logic [CW-1:0]        r_n;
    logic [CW-1:0]        r_count [NQU];
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [CW-1:0]        cnt;
    logic                 bad_q;
    logic                 full;
    logic                 empty;
    logic [IW-1:0]        parent_idx;
    logic [PW-1:0]        left_idx;
    logic [PW-1:0]        right_idx;
    logic [PW-1:0]        m_ext;
    logic                 has_left;
    logic                 has_right;
    logic                 left_gt;
    logic                 right_gt;
    logic [IW-1:0]        best_idx;
    logic [KEY_WIDTH-1:0] best_val;
    logic [IW-1:0]        rd_idx;
    logic [AW-1:0]        ram_raddr;
    logic [AW-1:0]        ram_waddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic [KEY_WIDTH-1:0] ram_rdata;
    logic [STATUS_W-1:0]  res_status;
    logic [CW-1:0]        res_count;
    logic [KEY_WIDTH-1:0] res_key;
    logic                 res_ok;
    logic                 out_free;

    assign bad_q = {1'b0, r_q} >= (QSEL_W + 1)'(NQU);
    assign cnt   = r_count[r_q[QIW-1:0]];
    assign full  = cnt >= CW'(QUEUE_DEPTH);
    assign empty = cnt == '0;

    assign parent_idx = (r_pos - IW'(1)) >> 1;
    assign left_idx   = (PW'(r_pos) << 1) + PW'(1);
    assign right_idx  = (PW'(r_pos) << 1) + PW'(2);
    assign m_ext      = PW'(r_n);
    assign has_left   = left_idx < m_ext;
    assign has_right  = right_idx < m_ext;

    // Larger child wins; on a tie the left child is kept.
    assign left_gt  = r_left > r_key;
    assign right_gt = has_right && (ram_rdata > (left_gt ? r_left : r_key));
    assign best_idx = right_gt ? right_idx[IW-1:0] : left_idx[IW-1:0];
    assign best_val = right_gt ? ram_rdata : r_left;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_ROOT:   rd_idx = '0;
            RD_LAST:   rd_idx = r_n[IW-1:0];
            RD_PARENT: rd_idx = parent_idx;
            RD_LEFT:   rd_idx = left_idx[IW-1:0];
            RD_RIGHT:  rd_idx = right_idx[IW-1:0];
            default:   rd_idx = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WR_KEY:   ram_wdata = r_key;
            WR_RDATA: ram_wdata = ram_rdata;
            WR_CHILD: ram_wdata = best_val;
            default:  ram_wdata = r_key;
        endcase
    end

    assign ram_raddr = r_base + AW'(rd_idx);
    assign ram_waddr = r_base + AW'(r_pos);

    mqbh_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        res_ok     = 1'b0;
        res_status = STATUS_OK;
        res_count  = cnt;
        res_key    = '0;
        if (bad_q) begin
            res_status = (r_action == ACT_EXTRACT) ? STATUS_EMPTY : STATUS_FULL;
            res_count  = '0;
        end else if ((r_action == ACT_INSERT) && full) begin
            res_status = STATUS_FULL;
        end else if ((r_action == ACT_EXTRACT) && empty) begin
            res_status = STATUS_EMPTY;
        end else begin
            res_ok    = 1'b1;
            res_count = r_n;
            if (r_action == ACT_EXTRACT) begin
                res_key = r_root ^ KEY_SIGN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_in_data.action;
            r_q      <= i_in_data.queue_sel;
            r_base   <= AW'(i_in_data.queue_sel) * AW'(QUEUE_DEPTH);
            r_key    <= KEY_WIDTH'($unsigned(i_in_data.key_in)) ^ KEY_SIGN;
        end else if (i_cmd.cap_last) begin
            r_key <= ram_rdata;
        end
        if (i_cmd.init) begin
            if (r_action == ACT_INSERT) begin
                r_pos <= cnt[IW-1:0];
                r_n   <= cnt + CW'(1);
            end else begin
                r_pos <= '0;
                r_n   <= cnt - CW'(1);
            end
        end else if (i_cmd.step_up) begin
            r_pos <= parent_idx;
        end else if (i_cmd.step_down) begin
            r_pos <= best_idx;
        end
        if (i_cmd.cap_root) begin
            r_root <= ram_rdata;
        end
        if (i_cmd.cap_left) begin
            r_left <= ram_rdata;
        end
        if (i_cmd.finish) begin
            r_out.key_out     <= $signed(KEY_IO_W'(res_key));
            r_out.status      <= res_status;
            r_out.count_after <= COUNT_IO_W'(res_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NQU; i++) begin
                r_count[i] <= '0;
            end
        end else if (i_cmd.finish && res_ok) begin
            r_count[r_q[QIW-1:0]] <= r_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts             = '0;
        o_sts.is_ext      = r_action == ACT_EXTRACT;
        o_sts.bad_q       = bad_q;
        o_sts.full        = full;
        o_sts.empty       = empty;
        o_sts.pos_zero    = r_pos == '0;
        o_sts.parent_less = ram_rdata < r_key;
        o_sts.last_zero   = r_n == '0;
        o_sts.has_left    = has_left;
        o_sts.down_move   = left_gt || right_gt;
        o_sts.out_free    = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/multi_queue_binary_max_heap.sv
// Top level of the multi-queue binary max-heap priority queue.
`default_nettype none

// This block keeps a bank of independent binary max-heaps of signed keys, one
// per queue number, all held in a single on-chip key memory with one write port
// and one registered read port. Each input transaction either inserts key_in
// into the queue named by queue_sel or extracts that queue's largest key, and
// each input transaction produces exactly one output transaction carrying the
// extracted key (zero for an insert or a failed extract), a status code and the
// queue's entry count after the operation. An insert into a full queue is
// dropped with a full status, an extract from an empty queue reports empty, and
// a queue number at or above NUM_QUEUES behaves as a queue of zero capacity.
// One transaction is worked on at a time. An insert does one memory read and
// one compare with write per heap level the new key climbs; an extract does
// reads of both children, then compare and write, per level the moved key
// sinks. With the default depth of 128 a new key climbs at most seven levels
// and a moved key sinks at most six. The result sits in an output register,
// so a new input transaction is taken while an earlier result still waits
// for the downstream side. The key memory needs no clearing after reset; the
// per-queue counts reset to zero, so only written entries are ever used.

module multi_queue_binary_max_heap #(
    parameter int QUEUE_DEPTH = mqbh_pkg::MQBH_QUEUE_DEPTH,
    parameter int NUM_QUEUES  = mqbh_pkg::MQBH_NUM_QUEUES,
    parameter int KEY_WIDTH   = mqbh_pkg::MQBH_KEY_WIDTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire mqbh_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output mqbh_pkg::t_out_item      o_out_data
);
    import mqbh_pkg::*;

    // Commands flow from the sequencer to the datapath, status flows back.
    t_cmd cmd;
    t_sts sts;

    mqbh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mqbh_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_QUEUES  (NUM_QUEUES),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
